>>> rtl/qebe_pkg.sv
// Shared types and constants for the quadrature encoder / button event block.
// No dependencies.
package qebe_pkg;

  typedef enum logic [1:0] {
    KIND_LEFT  = 2'd0,
    KIND_RIGHT = 2'd1,
    KIND_PUSH  = 2'd2
  } event_kind_t;

  localparam logic [1:0] MODE_CTRL_ADJ  = 2'd0;
  localparam logic [1:0] MODE_SEQUENCER = 2'd1;

  localparam logic DEST_CONTROLLER = 1'b0;
  localparam logic DEST_GUI        = 1'b1;

  typedef struct packed {
    logic [7:0] encoder_lines;
    logic [7:0] button_lines;
  } in_req_t;

  typedef struct packed {
    event_kind_t event_kind;
    logic [1:0]  knob_index;
    logic        destination;
    logic        last_event;
  } out_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

>>> rtl/quad_encoder_button_events_core.sv
// Quadrature encoder and button event block, top level. Uses qebe_pkg.
// Path: job queue, back end, output register. Throughput: one sample per cycle
// into a two-entry job queue while it is not full; the back end emits one event
// per cycle while out_req is empty or popped.
// Reset (synchronous, rst_n low): previous sample zero, mode controller,
// queue and output register empty.
module quad_encoder_button_events_core
  import qebe_pkg::*;
#(
  parameter int KNOB_COUNT = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  in_req_t    in_req,
  output logic       in_full,
  output logic       out_empty,
  input  logic       out_pop,
  output out_req_t   out_req,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_data
);

  localparam int JOB_W = 3 * KNOB_COUNT + 1;

  q_stat_t          q_stat;
  logic             q_wr, q_rd;
  logic [JOB_W-1:0] q_wdata, q_rdata;

  qebe_front #(.KNOB_COUNT(KNOB_COUNT), .JOB_W(JOB_W)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_req    (in_req),
    .in_full   (in_full),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_stat    (q_stat),
    .q_wr      (q_wr),
    .q_wdata   (q_wdata)
  );

  qebe_job_fifo #(.WIDTH(JOB_W), .DEPTH(2)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (q_wr),
    .wdata (q_wdata),
    .rd    (q_rd),
    .rdata (q_rdata),
    .stat  (q_stat)
  );

  qebe_back #(.KNOB_COUNT(KNOB_COUNT), .JOB_W(JOB_W)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_rdata   (q_rdata),
    .q_rd      (q_rd),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_req   (out_req)
  );

endmodule

>>> rtl/qebe_front.sv
// Front end: keeps the previous sample and the mode, classifies each sample
// into a job (step mask, step directions, push mask, destination). Uses qebe_pkg.
module qebe_front
  import qebe_pkg::*;
#(
  parameter int KNOB_COUNT = 4,
  parameter int JOB_W      = 3 * KNOB_COUNT + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_push,
  input  in_req_t          in_req,
  output logic             in_full,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_data,
  input  q_stat_t          q_stat,
  output logic             q_wr,
  output logic [JOB_W-1:0] q_wdata
);

  logic [KNOB_COUNT-1:0] prev_b_r;
  logic [7:0]            prev_btn_r;
  logic [1:0]            mode_r;
  logic [KNOB_COUNT-1:0] a_c, b_c, step_c, push_c;
  logic                  steps_on;
  logic                  accept;

  assign cfg_ready = 1'b1;
  assign in_full   = q_stat.full;
  assign accept    = in_push && !q_stat.full;
  assign steps_on  = (mode_r == MODE_CTRL_ADJ) || (mode_r == MODE_SEQUENCER);

  always_comb begin
    for (int k = 0; k < KNOB_COUNT; k++) begin
      a_c[k]    = in_req.encoder_lines[7-2*k];
      b_c[k]    = in_req.encoder_lines[6-2*k];
      step_c[k] = steps_on && !a_c[k] && (b_c[k] != prev_b_r[k]);
      push_c[k] = prev_btn_r[7-k] && !in_req.button_lines[7-k];
    end
  end

  assign q_wdata = {mode_r[0], b_c, push_c, step_c};
  assign q_wr    = accept && ((step_c != '0) || (push_c != '0));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_b_r   <= '0;
      prev_btn_r <= '0;
      mode_r     <= MODE_CTRL_ADJ;
    end else begin
      if (accept) begin
        prev_b_r   <= b_c;
        prev_btn_r <= in_req.button_lines;
      end
      if (cfg_valid) begin
        mode_r <= cfg_data;
      end
    end
  end

endmodule

>>> rtl/qebe_job_fifo.sv
// Small flop-based job queue between front and back end.
// Uses qebe_pkg for the status struct.
module qebe_job_fifo
  import qebe_pkg::*;
#(
  parameter int WIDTH = 13,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output q_stat_t          stat
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_wr, do_rd;

  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign do_wr      = wr && !stat.full;
  assign do_rd      = rd && !stat.empty;
  assign rdata      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_rd) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

>>> rtl/qebe_back.sv
// Back end: walks one job's event mask into an output register, one event per
// cycle while that register is empty or popped. Uses qebe_pkg.
module qebe_back
  import qebe_pkg::*;
#(
  parameter int KNOB_COUNT = 4,
  parameter int JOB_W      = 3 * KNOB_COUNT + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  q_stat_t          q_stat,
  input  logic [JOB_W-1:0] q_rdata,
  output logic             q_rd,
  output logic             out_empty,
  input  logic             out_pop,
  output out_req_t         out_req
);

  localparam int EV_N = 2 * KNOB_COUNT;

  logic                  busy_r, busy_nxt;
  logic [EV_N-1:0]       rem_r, rem_nxt;
  logic [KNOB_COUNT-1:0] dir_r, dir_nxt;
  logic                  dest_r, dest_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_req_t              out_r, out_nxt;
  logic [EV_N-1:0]       low_bit, rem_left;
  logic [1:0]            sel_knob;
  logic                  sel_push;
  logic                  adv, last_c, take;

  assign low_bit  = rem_r & (~rem_r + 1'b1);
  assign rem_left = rem_r & ~low_bit;
  assign last_c   = (rem_left == '0);
  assign adv      = !out_valid_r || out_pop;
  assign take     = !q_stat.empty && (!busy_r || (adv && last_c));
  assign q_rd     = take;

  always_comb begin
    sel_knob = '0;
    sel_push = 1'b0;
    for (int i = 0; i < EV_N; i++) begin
      if (low_bit[i]) begin
        sel_push = (i >= KNOB_COUNT);
        sel_knob = (i >= KNOB_COUNT) ? 2'(i - KNOB_COUNT) : 2'(i);
      end
    end
  end

  always_comb begin
    busy_nxt      = busy_r;
    rem_nxt       = rem_r;
    dir_nxt       = dir_r;
    dest_nxt      = dest_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (adv) begin
      out_valid_nxt = busy_r;
      if (busy_r) begin
        rem_nxt             = rem_left;
        out_nxt.knob_index  = sel_knob;
        out_nxt.last_event  = last_c;
        if (sel_push) begin
          out_nxt.event_kind  = KIND_PUSH;
          out_nxt.destination = DEST_GUI;
        end else begin
          out_nxt.event_kind  = dir_r[sel_knob] ? KIND_LEFT : KIND_RIGHT;
          out_nxt.destination = dest_r;
        end
        if (last_c) busy_nxt = 1'b0;
      end
    end
    if (take) begin
      busy_nxt = 1'b1;
      rem_nxt  = q_rdata[EV_N-1:0];
      dir_nxt  = q_rdata[EV_N+KNOB_COUNT-1:EV_N];
      dest_nxt = q_rdata[JOB_W-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r  <= rem_nxt;
    dir_r  <= dir_nxt;
    dest_r <= dest_nxt;
    out_r  <= out_nxt;
  end

  assign out_empty = !out_valid_r;
  assign out_req   = out_r;

endmodule

>>> dv/quad_encoder_button_events_core_tb.sv
// Self-checking testbench for quad_encoder_button_events_core: a table of directed samples,
// then random quadrature sequences, each result checked against listed or modelled events.
// Depends on rtl/qebe_pkg.sv and rtl/quad_encoder_button_events_core.sv.
module quad_encoder_button_events_core_tb;
  import qebe_pkg::*;

  localparam int KNOBS = 4;
  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 6;
  localparam int PHASE_ITEMS = 100;
  localparam logic [1:0] MODE_IGNORE = 2'd2;
  localparam logic [1:0] MODE_IGNORE_ALT = 2'd3;

  typedef struct packed {
    logic             is_cfg;
    logic [1:0]       mode;
    in_req_t          smp;
    logic             typed;
    logic [2:0]       n;
    out_req_t [0:3]   ev;
  } row_t;

  logic clk = 1'b1;
  logic rst_n = 1'b0;
  logic in_push = 1'b0;
  in_req_t in_req = '0;
  logic in_full;
  logic out_empty;
  logic out_pop = 1'b0;
  out_req_t out_req;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_data = '0;

  // decoder model state
  logic [1:0] mode_q;
  logic [3:0] prev_b;
  logic [7:0] prev_btn;

  out_req_t pending_events[$];
  int mismatches = 0;
  bit calm = 1'b0;
  bit backlog_req = 1'b0;
  int stall_cycles = 0;

  quad_encoder_button_events_core #(.KNOB_COUNT(KNOBS)) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_push(in_push),
    .in_req(in_req),
    .in_full(in_full),
    .out_empty(out_empty),
    .out_pop(out_pop),
    .out_req(out_req),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b0;
    #5 clk = 1'b1;
  end

  function automatic out_req_t ev(event_kind_t kind, logic [1:0] knob, logic dest,
                                  logic last);
    out_req_t e;
    e.event_kind = kind;
    e.knob_index = knob;
    e.destination = dest;
    e.last_event = last;
    return e;
  endfunction

  function automatic row_t smp_row(logic [7:0] enc, logic [7:0] btn, logic typed = 1'b0,
                                   int n = 0, out_req_t e0 = '0, out_req_t e1 = '0,
                                   out_req_t e2 = '0, out_req_t e3 = '0);
    row_t r;
    r = '0;
    r.smp.encoder_lines = enc;
    r.smp.button_lines = btn;
    r.typed = typed;
    r.n = n[2:0];
    r.ev[0] = e0;
    r.ev[1] = e1;
    r.ev[2] = e2;
    r.ev[3] = e3;
    return r;
  endfunction

  function automatic row_t cfg_row(logic [1:0] m);
    row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.mode = m;
    return r;
  endfunction

  // x1 decode of one sample against the previous one; updates the kept sample
  function automatic int decode_sample(in_req_t s, output out_req_t [7:0] evs);
    logic [3:0] a, b, b_chg;
    logic [7:0] fall;
    int n;
    n = 0;
    evs = '0;
    for (int k = 0; k < 4; k++) begin
      a[k] = s.encoder_lines[7-2*k];
      b[k] = s.encoder_lines[6-2*k];
    end
    b_chg = b ^ prev_b;
    for (int k = 0; k < KNOBS; k++) begin
      if (!a[k] && b_chg[k] && (mode_q == MODE_CTRL_ADJ || mode_q == MODE_SEQUENCER)) begin
        evs[n] = ev(b[k] ? KIND_LEFT : KIND_RIGHT, k[1:0],
                    (mode_q == MODE_SEQUENCER) ? DEST_GUI : DEST_CONTROLLER, 1'b0);
        n++;
      end
    end
    fall = prev_btn & ~s.button_lines;
    for (int k = 0; k < KNOBS; k++) begin
      if (fall[7-k]) begin
        evs[n] = ev(KIND_PUSH, k[1:0], DEST_GUI, 1'b0);
        n++;
      end
    end
    if (n > 0) evs[n-1].last_event = 1'b1;
    prev_b = b;
    prev_btn = s.button_lines;
    return n;
  endfunction

  task automatic offer_sample(row_t r);
    out_req_t [7:0] got;
    int cnt;
    in_push <= 1'b1;
    in_req <= r.smp;
    @(posedge clk);
    while (in_full) @(posedge clk);
    cnt = decode_sample(r.smp, got);
    if (r.typed) begin
      for (int i = 0; i < r.n; i++) pending_events.push_back(r.ev[i]);
    end else begin
      for (int i = 0; i < cnt; i++) pending_events.push_back(got[i]);
    end
  endtask

  task automatic drain_requests();
    in_push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(logic [1:0] m);
    drain_requests();
    cfg_valid <= 1'b1;
    cfg_data <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    mode_q = m;
    cfg_valid <= 1'b0;
  endtask

  task automatic maybe_pause();
    if (!calm && $urandom_range(99) < 12) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
  endtask

  // result side: check each popped result, then decide the next pop
  initial begin : result_side
    out_req_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (pending_events.size() == 0) begin
          $error("unexpected result: event_kind=%0d knob_index=%0d", out_req.event_kind,
                 out_req.knob_index);
          mismatches++;
        end else begin
          want = pending_events.pop_front();
          if (out_req.event_kind !== want.event_kind) begin
            $error("event_kind: expected %0d, got %0d", want.event_kind, out_req.event_kind);
            mismatches++;
          end
          if (out_req.knob_index !== want.knob_index) begin
            $error("knob_index: expected %0d, got %0d", want.knob_index, out_req.knob_index);
            mismatches++;
          end
          if (out_req.destination !== want.destination) begin
            $error("destination: expected %0d, got %0d", want.destination,
                   out_req.destination);
            mismatches++;
          end
          if (out_req.last_event !== want.last_event) begin
            $error("last_event: expected %0d, got %0d", want.last_event, out_req.last_event);
            mismatches++;
          end
        end
      end
      if (backlog_req) begin
        backlog_req = 1'b0;
        out_pop <= 1'b0;
        repeat (300) @(posedge clk);
      end else begin
        out_pop <= calm || ($urandom_range(99) >= 12);
      end
    end
  end

  initial begin : watchdog
    while (stall_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $display("quad_encoder_button_events_core_tb NOT OK");
    $finish;
  end

  initial begin : stimulus
    row_t dir_table[$];
    row_t r;
    logic [1:0] knob_pos[4];
    logic [1:0] phase_modes[5];
    logic [7:0] enc, btn_hold;
    int step;

    mode_q = MODE_CTRL_ADJ;
    prev_b = '0;
    prev_btn = '0;

    dir_table.push_back(smp_row(8'h00, 8'h00, 1'b1, 0));
    dir_table.push_back(smp_row(8'h55, 8'hFF, 1'b1, 4,
      ev(KIND_LEFT, 2'd0, DEST_CONTROLLER, 1'b0), ev(KIND_LEFT, 2'd1, DEST_CONTROLLER, 1'b0),
      ev(KIND_LEFT, 2'd2, DEST_CONTROLLER, 1'b0), ev(KIND_LEFT, 2'd3, DEST_CONTROLLER, 1'b1)));
    dir_table.push_back(smp_row(8'h00, 8'h7F));
    dir_table.push_back(smp_row(8'hFF, 8'h00));
    dir_table.push_back(smp_row(8'hFF, 8'h0F, 1'b1, 0));
    dir_table.push_back(smp_row(8'hAA, 8'h00, 1'b1, 0));
    dir_table.push_back(cfg_row(MODE_SEQUENCER));
    dir_table.push_back(smp_row(8'h55, 8'hFF));
    dir_table.push_back(smp_row(8'h00, 8'h00));
    dir_table.push_back(cfg_row(MODE_IGNORE));
    dir_table.push_back(smp_row(8'h55, 8'hFF, 1'b1, 0));
    dir_table.push_back(smp_row(8'h00, 8'h7F, 1'b1, 1, ev(KIND_PUSH, 2'd0, DEST_GUI, 1'b1)));
    dir_table.push_back(cfg_row(MODE_IGNORE_ALT));
    dir_table.push_back(smp_row(8'h55, 8'h00));
    dir_table.push_back(cfg_row(MODE_CTRL_ADJ));
    dir_table.push_back(smp_row(8'h15, 8'h00, 1'b1, 1,
      ev(KIND_RIGHT, 2'd0, DEST_CONTROLLER, 1'b1)));
    dir_table.push_back(smp_row(8'h80, 8'h00));
    dir_table.push_back(smp_row(8'h40, 8'h80));

    phase_modes[0] = MODE_SEQUENCER;
    phase_modes[1] = MODE_IGNORE;
    phase_modes[2] = MODE_CTRL_ADJ;
    phase_modes[3] = MODE_IGNORE_ALT;
    phase_modes[4] = MODE_SEQUENCER;
    for (int k = 0; k < 4; k++) knob_pos[k] = 2'd0;
    btn_hold = 8'hFF;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_table[i]) begin
      if (dir_table[i].is_cfg) begin
        write_mode(dir_table[i].mode);
      end else begin
        maybe_pause();
        offer_sample(dir_table[i]);
      end
    end

    for (int p = 0; p < 5; p++) begin
      write_mode(phase_modes[p]);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        calm = (p == 2 && i < 60);
        if (p == 0 && i == 30) backlog_req = 1'b1;
        if ($urandom_range(99) < 15) begin
          enc = 8'($urandom);
          btn_hold = 8'($urandom);
        end else begin
          // one Gray-code detent per knob, either way, or none
          for (int k = 0; k < 4; k++) begin
            step = $urandom_range(3);
            if (step == 1) knob_pos[k] = knob_pos[k] + 2'd1;
            else if (step == 2) knob_pos[k] = knob_pos[k] - 2'd1;
            enc[7-2*k] = knob_pos[k][1];
            enc[6-2*k] = knob_pos[k][1] ^ knob_pos[k][0];
          end
          if ($urandom_range(99) < 20) btn_hold[7 - $urandom_range(3)] ^= 1'b1;
          if ($urandom_range(99) < 10) btn_hold[3:0] = 4'($urandom);
        end
        r = smp_row(enc, btn_hold);
        maybe_pause();
        offer_sample(r);
      end
      calm = 1'b0;
    end

    drain_requests();
    repeat (10) @(posedge clk);
    if (mismatches == 0)
      $display("quad_encoder_button_events_core_tb OK");
    else
      $display("quad_encoder_button_events_core_tb NOT OK");
    $finish;
  end

endmodule
